// ===== rtl/core/kmp_pkg.sv =====
// Shared constants, types and controller state codes for the k-transaction profit block.
package kmp_pkg;

   localparam int MAX_LEVELS_DEF = 16;
   localparam int PRICE_W        = 16;
   localparam int PROFIT_W       = 32;
   localparam int HOLD_W         = 33;
   localparam int EXT_W          = HOLD_W + 1;
   localparam int KCFG_W         = 5;
   localparam logic [KCFG_W-1:0] KCFG_RESET = KCFG_W'(2);

   // Controller to datapath command bundle
   typedef struct packed {
      logic load;      // latch a new item, clear carry and result
      logic rd_en;     // read one level pair
      logic wr_en;     // update the level pair read last cycle
      logic out_load;  // move the finished result to the output register
   } dp_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SWEEP = 3'b010,
      ST_DONE  = 3'b100
   } ctrl_state_type;

endpackage

// ===== rtl/core/kmp_dpath.sv =====
// Datapath: level memories, per-level update arithmetic, result capture and config register.
module kmp_dpath #(
   parameter int MAX_LEVELS = kmp_pkg::MAX_LEVELS_DEF,
   parameter int LVL_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kmp_pkg::dp_cmd_type           cmd,
   input  logic [LVL_W-1:0]              rd_addr,
   input  logic [LVL_W-1:0]              wr_addr,
   input  logic [kmp_pkg::PRICE_W-1:0]   req_price,
   input  logic                          req_first_day,
   input  logic                          csr_wr,
   input  logic [kmp_pkg::KCFG_W-1:0]    csr_max_transactions,
   output logic [kmp_pkg::PROFIT_W-1:0]  rsp_best_profit
);
   import kmp_pkg::*;

   logic [PROFIT_W-1:0]      profit_mem [MAX_LEVELS];
   logic [HOLD_W-1:0]        hold_mem   [MAX_LEVELS];
   logic [MAX_LEVELS-1:0]    valid_ff, valid_in;

   logic [KCFG_W-1:0]        kcfg_ff;
   logic [PRICE_W-1:0]       price_ff;
   logic                     first_ff;
   logic                     cap_en_ff, cap_en_in;
   logic [LVL_W-1:0]         cap_idx_ff, cap_idx_in;
   logic [PROFIT_W-1:0]      carry_ff, carry_in;
   logic [PROFIT_W-1:0]      result_ff, result_in;
   logic [PROFIT_W-1:0]      prof_rd_ff;
   logic                     prof_vld_rd_ff;
   logic [HOLD_W-1:0]        hold_rd_ff;
   logic [PROFIT_W-1:0]      out_ff;

   logic [PROFIT_W-1:0]      old_prof;
   logic signed [EXT_W-1:0]  price_ext, sell, old_ext, cand, buy, hold_ext;
   logic [PROFIT_W-1:0]      prof_new;
   logic [HOLD_W-1:0]        hold_new;
   logic                     k_over;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         kcfg_ff <= KCFG_RESET;
      end else if (csr_wr) begin
         kcfg_ff <= csr_max_transactions;
      end
   end

   // level pair update
   always_comb begin
      old_prof  = prof_vld_rd_ff ? prof_rd_ff : '0;
      price_ext = $signed({{(EXT_W-PRICE_W){1'b0}}, price_ff});
      old_ext   = $signed({{(EXT_W-PROFIT_W){1'b0}}, old_prof});
      hold_ext  = $signed({hold_rd_ff[HOLD_W-1], hold_rd_ff});
      sell      = price_ext + hold_ext;
      buy       = $signed({{(EXT_W-PROFIT_W){1'b0}}, carry_ff}) - price_ext;
      cand      = (sell > old_ext) ? sell : old_ext;
      if (cand > $signed({{(EXT_W-PROFIT_W){1'b0}}, {PROFIT_W{1'b1}}})) begin
         prof_new = {PROFIT_W{1'b1}};
      end else begin
         prof_new = cand[PROFIT_W-1:0];
      end
      hold_new = (buy > hold_ext) ? buy[HOLD_W-1:0] : hold_rd_ff;
      if (first_ff) begin
         prof_new = '0;
         hold_new = HOLD_W'(0) - {{(HOLD_W-PRICE_W){1'b0}}, price_ff};
      end
   end

   // K above the built level count selects the top level
   always_comb begin
      k_over     = (int'(kcfg_ff) > MAX_LEVELS);
      cap_idx_in = k_over ? LVL_W'(MAX_LEVELS - 1) : LVL_W'(kcfg_ff - KCFG_W'(1));
      cap_en_in  = !req_first_day && (kcfg_ff != '0);
   end

   always_comb begin
      valid_in  = valid_ff;
      carry_in  = carry_ff;
      result_in = result_ff;
      if (cmd.load) begin
         carry_in  = '0;
         result_in = '0;
      end else if (cmd.wr_en) begin
         valid_in[wr_addr] = 1'b1;
         carry_in          = old_prof;
         if (cap_en_ff && (wr_addr == cap_idx_ff)) begin
            result_in = prof_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff  <= carry_in;
      result_ff <= result_in;
      if (cmd.load) begin
         price_ff   <= req_price;
         first_ff   <= req_first_day;
         cap_en_ff  <= cap_en_in;
         cap_idx_ff <= cap_idx_in;
      end
      if (cmd.out_load) begin
         out_ff <= result_ff;
      end
   end

   // memories, registered read
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         prof_rd_ff     <= profit_mem[rd_addr];
         hold_rd_ff     <= hold_mem[rd_addr];
         prof_vld_rd_ff <= valid_ff[rd_addr];
      end
      if (cmd.wr_en) begin
         profit_mem[wr_addr] <= prof_new;
         hold_mem[wr_addr]   <= hold_new;
      end
   end

   assign rsp_best_profit = out_ff;

endmodule

// ===== rtl/core/kmp_ctrl.sv =====
// Controller: sequences the level sweep and owns both handshakes.
module kmp_ctrl #(
   parameter int MAX_LEVELS = kmp_pkg::MAX_LEVELS_DEF,
   parameter int LVL_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kmp_pkg::dp_cmd_type  cmd,
   output logic [LVL_W-1:0]     rd_addr,
   output logic [LVL_W-1:0]     wr_addr
);
   import kmp_pkg::*;

   localparam logic [LVL_W-1:0] LAST_IDX = LVL_W'(MAX_LEVELS - 1);

   ctrl_state_type     state_ff, state_in;
   logic [LVL_W-1:0]   idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      rd_addr      = '0;
      wr_addr      = idx_ff;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load  = 1'b1;
               cmd.rd_en = 1'b1;
               idx_in    = '0;
               state_in  = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            cmd.wr_en = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end else begin
               cmd.rd_en = 1'b1;
               rd_addr   = idx_ff + LVL_W'(1);
               idx_in    = idx_ff + LVL_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/k_transaction_max_profit.sv =====
// Top level: best profit with at most K buy-sell transactions over a price stream.
// Sequence: ST_IDLE takes an item, ST_SWEEP then updates each level in turn,
//   one profit/holding memory read and one write per level, and ST_DONE loads
//   the result once the previous one is taken; only then is a new item accepted.
// Reset: synchronous, active high; K returns to 2, all level profits read as zero,
//   holdings are undefined until a first_day item writes them.
module k_transaction_max_profit #(
   parameter int MAX_LEVELS = kmp_pkg::MAX_LEVELS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // price input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [kmp_pkg::PRICE_W-1:0]   req_price,
   input  logic                          req_first_day,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [kmp_pkg::PROFIT_W-1:0]  rsp_best_profit,
   // max_transactions write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [kmp_pkg::KCFG_W-1:0]    csr_max_transactions
);
   import kmp_pkg::*;

   localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

   dp_cmd_type          cmd;
   logic [LVL_W-1:0]    rd_addr;
   logic [LVL_W-1:0]    wr_addr;

   // Config writes must come only when idle (unchecked); csr_ready is always 1.
   assign csr_ready = 1'b1;

   // Controller walks levels 0..MAX_LEVELS-1 in ascending order; the datapath
   // carries the previous level's old profit in a register, so each level needs
   // only one read per memory.
   kmp_ctrl #(
      .MAX_LEVELS (MAX_LEVELS),
      .LVL_W      (LVL_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr)
   );

   kmp_dpath #(
      .MAX_LEVELS (MAX_LEVELS),
      .LVL_W      (LVL_W)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .rd_addr              (rd_addr),
      .wr_addr              (wr_addr),
      .req_price            (req_price),
      .req_first_day        (req_first_day),
      .csr_wr               (csr_valid && csr_ready),
      .csr_max_transactions (csr_max_transactions),
      .rsp_best_profit      (rsp_best_profit)
   );

   // One item in flight: no new transfer right after one is taken.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req accepted twice in a row");

   // Every level read is consumed by an update in the next cycle.
   a_read_then_write: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |=> cmd.wr_en)
      else $error("level read not followed by update");

   // A pending result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten");

   // Level updates only happen while the input side is closed.
   a_busy_during_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> !req_ready)
      else $error("input open during sweep");

endmodule

// ===== dv/kmp_profit_checker.sv =====
`timescale 1ns / 1ps
// Checker for the k-transaction profit block: predicts each day's best profit and compares.
module kmp_profit_checker #(
   parameter int MAX_LEVELS = kmp_pkg::MAX_LEVELS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [kmp_pkg::PRICE_W-1:0]  req_price,
   input  logic                         req_first_day,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [kmp_pkg::PROFIT_W-1:0] rsp_best_profit,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [kmp_pkg::KCFG_W-1:0]   csr_max_transactions,
   output int                           n_errors,
   output int                           n_pending,
   output int                           n_checked
);
   import kmp_pkg::*;

   // signed cash wide enough for price + holding without wrap
   typedef logic signed [EXT_W-1:0] cash_type;

   localparam cash_type PROFIT_CAP = cash_type'({{(EXT_W-PROFIT_W){1'b0}}, {PROFIT_W{1'b1}}});

   logic [KCFG_W-1:0]   k_setting;
   logic [PROFIT_W-1:0] cash_best [MAX_LEVELS];
   cash_type            cash_hold [MAX_LEVELS];
   logic [PROFIT_W-1:0] profit_due [$];
   logic [PROFIT_W-1:0] due;

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $time, what);
      n_errors++;
   endtask

   // advance all levels by one day, return best profit at level K
   function automatic logic [PROFIT_W-1:0] next_day_profit(input logic [PRICE_W-1:0] price,
                                                           input logic first);
      cash_type p, prof, hold, lower, sell, buy;
      int k;
      p = cash_type'(price);
      k = (k_setting > MAX_LEVELS) ? MAX_LEVELS : int'(k_setting);
      if (first) begin
         for (int t = 0; t < MAX_LEVELS; t++) begin
            cash_best[t] = '0;
            cash_hold[t] = -p;
         end
         return '0;
      end
      // top level first so the lower level still holds yesterday's profit
      for (int t = MAX_LEVELS - 1; t >= 0; t--) begin
         prof  = cash_type'(cash_best[t]);
         hold  = cash_hold[t];
         lower = (t > 0) ? cash_type'(cash_best[t-1]) : cash_type'(0);
         sell  = p + hold;
         buy   = lower - p;
         if (sell > prof) prof = sell;
         if (prof > PROFIT_CAP) prof = PROFIT_CAP;
         if (buy > hold) hold = buy;
         cash_best[t] = prof[PROFIT_W-1:0];
         cash_hold[t] = hold;
      end
      return (k == 0) ? '0 : cash_best[k-1];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         k_setting = KCFG_RESET;
         for (int t = 0; t < MAX_LEVELS; t++) begin
            cash_best[t] = '0;
            cash_hold[t] = '0;
         end
         profit_due.delete();
         n_errors = 0;
         n_pending <= 0;
         n_checked <= 0;
      end else begin
         if (csr_valid && csr_ready) k_setting = csr_max_transactions;
         if (rsp_valid && rsp_ready) begin
            if (profit_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result, best_profit %0d", rsp_best_profit));
            end else begin
               due = profit_due.pop_front();
               n_checked <= n_checked + 1;
               if (rsp_best_profit !== due) begin
                  report_mismatch($sformatf("best_profit %0d, expected %0d",
                                            rsp_best_profit, due));
               end
            end
         end
         if (req_valid && req_ready) begin
            profit_due.push_back(next_day_profit(req_price, req_first_day));
         end
         n_pending <= profit_due.size();
      end
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top for the k-transaction profit block: clock, reset, stimulus and verdict.
module testbench;
   import kmp_pkg::*;

   localparam int LEVELS     = MAX_LEVELS_DEF;
   localparam int N_PHASES   = 9;
   localparam int PHASE_DAYS = 175;
   localparam int N_DIRECTED = 22;

   // shape of the prices within one random series
   typedef enum logic [1:0] {
      PAT_SWING,   // alternating near-extreme highs and lows, builds big profits fast
      PAT_DRIFT,   // bounded random walk
      PAT_NOISE    // uniform prices, exercises every price bit
   } day_pattern_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [PRICE_W-1:0]  req_price;
   logic                req_first_day;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [PROFIT_W-1:0] rsp_best_profit;
   logic                csr_valid;
   logic                csr_ready;
   logic [KCFG_W-1:0]   csr_max_transactions;

   int fail_count;
   int due_count;
   int checked_count;

   // percent of cycles in which the sender holds off / the receiver stalls
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;

   int              days_sent = 0;
   int              series_sent = 0;
   int              settings_done = 0;
   int              series_left = 0;
   day_pattern_type series_pattern = PAT_NOISE;
   int              drift_price = 32768;

   logic [KCFG_W-1:0] k_plan [N_PHASES] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd3, 5'd17, 5'd2, 5'd8,
                                            5'd0};

   // Directed days under the reset K of 2: series that open at the top and the bottom price,
   // full swings between 0 and 65535, one-step swings, repeated prices, a zero-price first day
   // and new series started in the middle of a run of days.
   logic [PRICE_W-1:0] dir_price [N_DIRECTED] = '{
      16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001,
      16'hFFFE, 16'h0000, 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF,
      16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
   logic dir_first [N_DIRECTED] = '{
      1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

   always #2 clock = ~clock;

   k_transaction_max_profit #(
      .MAX_LEVELS(LEVELS)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_price            (req_price),
      .req_first_day        (req_first_day),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_best_profit      (rsp_best_profit),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_transactions (csr_max_transactions)
   );

   kmp_profit_checker #(
      .MAX_LEVELS(LEVELS)
   ) i_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_price            (req_price),
      .req_first_day        (req_first_day),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_best_profit      (rsp_best_profit),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_transactions (csr_max_transactions),
      .n_errors             (fail_count),
      .n_pending            (due_count),
      .n_checked            (checked_count)
   );

   // Result side back-pressure: a fresh coin toss every cycle, so stalls land on every
   // phase of the sweep, including the cycle rsp_valid first rises.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // One day transfer. Optional hold-off first; valid is only dropped during a hold-off,
   // so back-to-back days keep valid high with no low/high pair in one time step.
   task automatic send_day(input logic [PRICE_W-1:0] price, input logic first);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_price     <= price;
      req_first_day <= first;
      do @(posedge clock); while (!req_ready);
      days_sent++;
      if (first) series_sent++;
   endtask

   // Stop sending and wait until every expected result has been transferred.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_count != 0);
   endtask

   // K write; only called with the block idle.
   task automatic write_k(input logic [KCFG_W-1:0] k);
      csr_valid            <= 1'b1;
      csr_max_transactions <= k;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_done++;
   endtask

   // Random series of random length and pattern. A phase may begin mid-series, so a
   // new K lands on levels that already carry history.
   task automatic run_phase(input int n_days);
      logic [PRICE_W-1:0] price;
      logic               first;
      for (int i = 0; i < n_days; i++) begin
         first = 1'b0;
         if (series_left == 0) begin
            first = 1'b1;
            // mostly short series, some long ones so the upper levels fill up
            series_left    = ($urandom_range(3) == 0) ? $urandom_range(300, 60)
                                                      : $urandom_range(20, 1);
            series_pattern = day_pattern_type'($urandom_range(2));
            drift_price    = $urandom_range(65535);
         end
         case (series_pattern)
            PAT_SWING: begin
               price = (series_left % 2) ? PRICE_W'($urandom_range(65535, 60000))
                                         : PRICE_W'($urandom_range(5000, 0));
            end
            PAT_DRIFT: begin
               drift_price = drift_price + int'($urandom_range(4000)) - 2000;
               if (drift_price < 0) drift_price = 0;
               if (drift_price > 65535) drift_price = 65535;
               price = PRICE_W'(drift_price);
            end
            default: begin
               price = PRICE_W'($urandom);
            end
         endcase
         series_left--;
         send_day(price, first);
      end
   endtask

   initial begin
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_price            <= '0;
      req_first_day        <= 1'b0;
      csr_valid            <= 1'b0;
      csr_max_transactions <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed days run at the reset K; the first one always opens a series, since
      // holdings are not defined before a first day
      tx_idle_pct = 13;
      rx_idle_pct = 63;
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_day(dir_price[i], dir_first[i]);
      end
      drain();

      // random phases: slow receiver, then slow sender, then full rate;
      // K covers zero, one, the level count, values above it and the top code
      k_plan[N_PHASES-1] = KCFG_W'($urandom_range(31));
      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph / 3)
            0: begin
               tx_idle_pct = 13;
               rx_idle_pct = 63;
            end
            1: begin
               tx_idle_pct = 63;
               rx_idle_pct = 13;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         write_k(k_plan[ph]);
         run_phase(PHASE_DAYS);
         drain();
      end

      // catch any stray result after the last one
      repeat (LEVELS + 4) @(posedge clock);

      $display("Summary: %0d days in %0d series, %0d results checked", days_sent, series_sent,
               checked_count);
      $display("Summary: %0d K writes incl. 0, 16 and above 16, three back-pressure modes",
               settings_done);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // hang guard, far above the slowest legal run
   initial begin
      #2ms;
      $display("Timeout: stimulus or results stuck");
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/kmp_pkg.sv
rtl/core/kmp_dpath.sv
rtl/core/kmp_ctrl.sv
rtl/core/k_transaction_max_profit.sv
dv/kmp_profit_checker.sv
dv/testbench.sv
